>>> rtl/lph_pkg.sv
package lph_pkg;

  localparam int MAX_LOG2 = 10;
  localparam int INIT_LOG2 = 4;
  localparam int START_LOG2 = (INIT_LOG2 > MAX_LOG2) ? MAX_LOG2 : INIT_LOG2;
  localparam int ADDR_W = MAX_LOG2 + 1;
  localparam int DEPTH = 2 << MAX_LOG2;
  localparam int KEY_W = 32;
  localparam int VAL_W = 64;
  localparam int CNT_W = 11;
  localparam int LOG_W = 4;
  localparam logic [31:0] HASH_MUL = 32'd2654435769;

  typedef enum logic [1:0] {
    ST_NEW      = 2'd0,
    ST_REPLACED = 2'd1,
    ST_FULL     = 2'd2,
    ST_CLEARED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_PROBE_START,
    DP_PROBE_STEP,
    DP_SCAN_START,
    DP_SCAN_STEP,
    DP_INS_START,
    DP_INS_STEP
  } dp_cmd_t;

  typedef enum logic [1:0] {
    RD_PROBE,
    RD_SCAN,
    RD_MOVE
  } rd_sel_t;

  typedef struct packed {
    dp_cmd_t cmd;
    rd_sel_t rd_sel;
    logic    mark_clear_start;
    logic    write_new;
    logic    write_val;
    logic    write_move;
    logic    swap_bank;
    logic    reset_table;
    logic    count_up;
  } lph_ctl_t;

  typedef struct packed {
    logic occ;
    logic key_eq;
    logic probe_wrapped;
    logic scan_done;
    logic clear_done;
    logic grow_needed;
  } lph_sts_t;

  function automatic logic [MAX_LOG2-1:0] home_slot(input logic [31:0] k,
                                                   input logic [LOG_W-1:0] lg);
    logic [31:0] h;
    logic [31:0] m;
    h = k * HASH_MUL;
    m = (32'd1 << lg) - 32'd1;
    return MAX_LOG2'(h & m);
  endfunction

endpackage

>>> rtl/linear_probe_hash_insert.sv
// Open-addressing hash table of 32-bit keys and 64-bit values with linear
// probing. Each insert walks the active bank one memory read per probe; an
// insert that must grow the table clears the other bank's 2^MAX_LOG2
// occupied marks, then rehashes every old slot with one read per scanned slot
// and one per probe. After reset and after a clear the block clears all
// 2^(MAX_LOG2+1) occupied marks, one a cycle, and stalls input until done.
// One result item per input item.
module linear_probe_hash_insert
  import lph_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 opcode,
  input  logic signed [31:0]   key,
  input  logic [63:0]          value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [9:0]           slot,
  output logic [1:0]           status,
  output logic [10:0]          entry_count,
  output logic [3:0]           capacity_log2,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  lph_ctl_t            ctl;
  lph_sts_t            sts;
  status_t             st_sel;
  logic                slot_zero;
  logic [4:0]          thresh;
  logic [MAX_LOG2-1:0] dp_slot;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {27'd0, thresh} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= 5'd12;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      thresh <= pwdata[4:0];
    end
  end

  lph_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .out_valid(out_valid), .out_stall(out_stall),
    .status_sel(st_sel), .slot_zero(slot_zero), .ctl(ctl), .sts(sts));

  lph_datapath u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts), .key_in(key), .value_in(value),
    .thresh(thresh), .slot_out(dp_slot), .count_out(entry_count),
    .log2_out(capacity_log2));

  assign slot = slot_zero ? 10'd0 : 10'(dp_slot);
  assign status = st_sel;

endmodule

>>> rtl/lph_ram.sv
module lph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/lph_datapath.sv
module lph_datapath
  import lph_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  lph_ctl_t             ctl,
  output lph_sts_t             sts,
  input  logic [KEY_W-1:0]     key_in,
  input  logic [VAL_W-1:0]     value_in,
  input  logic [4:0]           thresh,
  output logic [MAX_LOG2-1:0]  slot_out,
  output logic [CNT_W-1:0]     count_out,
  output logic [LOG_W-1:0]     log2_out
);

  // The occupied marks are one memory; valid bits are not needed because a
  // clearing pass runs after reset, on clear and on each new bank before rehash.
  logic [KEY_W-1:0]    key_r;
  logic [VAL_W-1:0]    val_r;
  logic                bank;
  logic [LOG_W-1:0]    lg;
  logic [CNT_W-1:0]    cnt;
  logic [MAX_LOG2-1:0] s;
  logic [MAX_LOG2:0]   n;
  logic [MAX_LOG2:0]   scan_i;
  logic [MAX_LOG2-1:0] ins_s;
  logic [ADDR_W-1:0]   clr_a;
  logic                clr_busy;
  logic                clr_all;
  logic [MAX_LOG2-1:0] cap_mask;
  logic [MAX_LOG2-1:0] new_mask;
  logic [KEY_W-1:0]    mv_key;
  logic [VAL_W-1:0]    mv_val;

  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr_k;
  logic              we_k;
  logic              we_v;
  logic [VAL_W-1:0]  wdata_v;
  logic [KEY_W-1:0]  wdata_k;
  logic              we_o;
  logic [ADDR_W-1:0] waddr_o;
  logic              wdata_o;
  logic [ADDR_W-1:0] raddr_o;
  logic [KEY_W-1:0]  rk;
  logic [VAL_W-1:0]  rv;
  logic              ro;

  assign cap_mask = MAX_LOG2'((32'd1 << lg) - 32'd1);
  assign new_mask = MAX_LOG2'((32'd2 << lg) - 32'd1);

  always_comb begin
    raddr   = {bank, s};
    raddr_o = {bank, s};
    unique case (ctl.rd_sel)
      RD_SCAN: begin
        raddr   = {bank, scan_i[MAX_LOG2-1:0]};
        raddr_o = {bank, scan_i[MAX_LOG2-1:0]};
      end
      RD_MOVE: raddr_o = {~bank, ins_s};
      default: ;
    endcase
  end

  always_comb begin
    we_k = 1'b0;
    we_v = 1'b0;
    waddr_k = {bank, s};
    wdata_k = key_r;
    wdata_v = val_r;
    we_o = 1'b0;
    waddr_o = {bank, s};
    wdata_o = 1'b1;
    if (clr_busy) begin
      we_o = 1'b1;
      waddr_o = clr_a;
      wdata_o = 1'b0;
    end else if (ctl.write_move) begin
      we_k = 1'b1;
      we_v = 1'b1;
      waddr_k = {~bank, ins_s};
      wdata_k = mv_key;
      wdata_v = mv_val;
      we_o = 1'b1;
      waddr_o = {~bank, ins_s};
    end else if (ctl.write_new) begin
      we_k = 1'b1;
      we_v = 1'b1;
      we_o = 1'b1;
    end else if (ctl.write_val) begin
      we_v = 1'b1;
    end
  end

  lph_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_keys (
    .clk(clk), .we(we_k), .waddr(waddr_k), .wdata(wdata_k), .raddr(raddr), .rdata(rk));
  lph_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_vals (
    .clk(clk), .we(we_v), .waddr(waddr_k), .wdata(wdata_v), .raddr(raddr), .rdata(rv));
  lph_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_occ (
    .clk(clk), .we(we_o), .waddr(waddr_o), .wdata(wdata_o), .raddr(raddr_o), .rdata(ro));

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
      lg <= LOG_W'(START_LOG2);
      cnt <= '0;
      clr_busy <= 1'b1;
      clr_all <= 1'b1;
      clr_a <= '0;
    end else begin
      if (clr_busy) begin
        clr_a <= clr_a + ADDR_W'(1);
        if (clr_all ? (clr_a == ADDR_W'(DEPTH - 1))
                    : (clr_a[MAX_LOG2-1:0] == {MAX_LOG2{1'b1}})) begin
          clr_busy <= 1'b0;
        end
      end
      if (ctl.mark_clear_start) begin
        clr_busy <= 1'b1;
        clr_all <= 1'b0;
        clr_a <= {~bank, {MAX_LOG2{1'b0}}};
      end
      if (ctl.reset_table) begin
        bank <= 1'b0;
        lg <= LOG_W'(START_LOG2);
        cnt <= '0;
        clr_busy <= 1'b1;
        clr_all <= 1'b1;
        clr_a <= '0;
      end
      if (ctl.swap_bank) begin
        bank <= ~bank;
        lg <= lg + LOG_W'(1);
      end
      if (ctl.count_up) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      DP_LOAD: begin
        key_r <= key_in;
        val_r <= value_in;
      end
      DP_PROBE_START: begin
        s <= home_slot(key_r, lg);
        n <= '0;
      end
      DP_PROBE_STEP: begin
        s <= (s + MAX_LOG2'(1)) & cap_mask;
        n <= n + (MAX_LOG2 + 1)'(1);
      end
      DP_SCAN_START: scan_i <= '0;
      DP_SCAN_STEP:  scan_i <= scan_i + (MAX_LOG2 + 1)'(1);
      DP_INS_START: begin
        mv_key <= rk;
        mv_val <= rv;
        ins_s <= home_slot(rk, lg + LOG_W'(1));
      end
      DP_INS_STEP: ins_s <= (ins_s + MAX_LOG2'(1)) & new_mask;
      default: ;
    endcase
  end

  logic [MAX_LOG2+4:0] lhs;
  logic [MAX_LOG2+5:0] rhs;
  assign lhs = {cnt + CNT_W'(1), 4'b0} >> (CNT_W - MAX_LOG2 - 1 > 0 ? 0 : 0);
  assign rhs = (MAX_LOG2 + 6)'(thresh) << lg;

  assign sts.occ = ro;
  assign sts.key_eq = (rk == key_r);
  assign sts.probe_wrapped = (n == ((MAX_LOG2 + 1)'(1) << lg) - (MAX_LOG2 + 1)'(1));
  assign sts.scan_done = (scan_i == ((MAX_LOG2 + 1)'(1) << lg) - (MAX_LOG2 + 1)'(1));
  assign sts.clear_done = ~clr_busy;
  assign sts.grow_needed = ((MAX_LOG2 + 6)'(lhs) > rhs) && (lg < LOG_W'(MAX_LOG2));

  assign slot_out = s;
  assign count_out = cnt;
  assign log2_out = lg;

endmodule

>>> rtl/lph_ctrl.sv
module lph_ctrl
  import lph_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     opcode,
  output logic     out_valid,
  input  logic     out_stall,
  output status_t  status_sel,
  output logic     slot_zero,
  output lph_ctl_t ctl,
  input  lph_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE, S_PSTART, S_PREAD, S_PCHK, S_GCLR, S_SREAD, S_SCHK,
    S_IREAD, S_ICHK, S_DONE, S_CLR
  } state_t;

  state_t state;
  logic   grown;

  assign in_stall = (state != S_IDLE) || !sts.clear_done || out_valid;

  always_comb begin
    ctl = '0;
    ctl.cmd = DP_NOP;
    ctl.rd_sel = RD_PROBE;
    unique case (state)
      S_IDLE:   if (in_valid && !in_stall) ctl.cmd = DP_LOAD;
      S_PSTART: ctl.cmd = DP_PROBE_START;
      S_PCHK: begin
        if (sts.occ && !sts.key_eq && !sts.probe_wrapped) ctl.cmd = DP_PROBE_STEP;
        else if (sts.occ && sts.key_eq) ctl.write_val = 1'b1;
        else if (!sts.occ && !(sts.grow_needed && !grown)) begin
          ctl.write_new = 1'b1;
          ctl.count_up = 1'b1;
        end else if (!sts.occ) ctl.mark_clear_start = 1'b1;
      end
      S_GCLR:  if (sts.clear_done) ctl.cmd = DP_SCAN_START;
      S_SREAD: ctl.rd_sel = RD_SCAN;
      S_SCHK: begin
        if (sts.occ) ctl.cmd = DP_INS_START;
        else if (sts.scan_done) ctl.swap_bank = 1'b1;
        else ctl.cmd = DP_SCAN_STEP;
      end
      S_ICHK: begin
        if (sts.occ) ctl.cmd = DP_INS_STEP;
        else begin
          ctl.write_move = 1'b1;
          if (sts.scan_done) ctl.swap_bank = 1'b1;
          else ctl.cmd = DP_SCAN_STEP;
        end
      end
      S_IREAD: ctl.rd_sel = RD_MOVE;
      S_CLR:   ctl.reset_table = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      grown <= 1'b0;
      status_sel <= ST_NEW;
      slot_zero <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          grown <= 1'b0;
          state <= opcode ? S_CLR : S_PSTART;
        end
        S_CLR: begin
          status_sel <= ST_CLEARED;
          slot_zero <= 1'b1;
          state <= S_DONE;
        end
        S_PSTART: state <= S_PREAD;
        S_PREAD:  state <= S_PCHK;
        S_PCHK: begin
          if (sts.occ && !sts.key_eq && !sts.probe_wrapped) state <= S_PREAD;
          else if (sts.occ && sts.key_eq) begin
            status_sel <= ST_REPLACED;
            slot_zero <= 1'b0;
            state <= S_DONE;
          end else if (sts.occ) begin
            status_sel <= ST_FULL;
            slot_zero <= 1'b1;
            state <= S_DONE;
          end else if (!(sts.grow_needed && !grown)) begin
            status_sel <= ST_NEW;
            slot_zero <= 1'b0;
            state <= S_DONE;
          end else begin
            grown <= 1'b1;
            state <= S_GCLR;
          end
        end
        S_GCLR: if (sts.clear_done) state <= S_SREAD;
        S_SREAD: state <= S_SCHK;
        S_SCHK: begin
          if (sts.occ) state <= S_IREAD;
          else if (sts.scan_done) state <= S_PSTART;
          else state <= S_SREAD;
        end
        S_IREAD: state <= S_ICHK;
        S_ICHK: begin
          if (sts.occ) state <= S_IREAD;
          else if (sts.scan_done) state <= S_PSTART;
          else state <= S_SREAD;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid)
    else $error("result not presented after completion");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst)
    ctl.write_new |-> !ctl.write_val)
    else $error("conflicting writes");

endmodule

>>> bench/linear_probe_hash_insert_test.sv
module linear_probe_hash_insert_test;
  import lph_pkg::*;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR = 1'b1;
  localparam logic [1:0] REG_GROW_THRESHOLD = 2'd0;
  localparam int BANK = 1 << MAX_LOG2;
  localparam int CYCLE_LIMIT = 3000000;

  typedef enum int {PROBE_EMPTY, PROBE_MATCH, PROBE_NONE} probe_t;

  typedef struct packed {
    logic        op;
    logic [31:0] k;
    logic [63:0] v;
  } table_op_t;

  typedef struct packed {
    logic [9:0]  slot;
    status_t     status;
    logic [10:0] count;
    logic [3:0]  lg;
  } insert_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = 1'b0;
  logic signed [31:0] key = '0;
  logic [63:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [9:0] slot;
  logic [1:0] status;
  logic [10:0] entry_count;
  logic [3:0] capacity_log2;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  linear_probe_hash_insert dut (.*);

  table_op_t pending_ops[$];
  insert_result_t expected_results[$];
  logic [31:0] key_pool[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0;
  int in_gap = 0;
  int out_hold = 0;

  logic [31:0] table_keys[DEPTH];
  logic [63:0] table_vals[DEPTH];
  bit table_occ[DEPTH];
  int cur_bank = 0;
  int cur_log2 = START_LOG2;
  int cur_count = 0;
  int threshold = 12;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int home_of(logic [31:0] k, int lg);
    logic [31:0] h;
    h = k * 32'd2654435769;
    return int'(h & ((32'd1 << lg) - 32'd1));
  endfunction

  function automatic probe_t find_slot(logic [31:0] k, output int s);
    int cap;
    int base;
    cap = 1 << cur_log2;
    base = cur_bank * BANK;
    s = home_of(k, cur_log2);
    for (int n = 0; n < cap; n++) begin
      if (!table_occ[base + s]) return PROBE_EMPTY;
      if (table_keys[base + s] == k) return PROBE_MATCH;
      s = (s + 1) & (cap - 1);
    end
    s = 0;
    return PROBE_NONE;
  endfunction

  function automatic void rehash_double();
    int old_base;
    int new_base;
    int new_cap;
    int s;
    old_base = cur_bank * BANK;
    new_base = (cur_bank ^ 1) * BANK;
    new_cap = 1 << (cur_log2 + 1);
    for (int i = 0; i < BANK; i++) table_occ[new_base + i] = 0;
    for (int i = 0; i < (1 << cur_log2); i++) begin
      if (table_occ[old_base + i]) begin
        s = home_of(table_keys[old_base + i], cur_log2 + 1);
        while (table_occ[new_base + s]) s = (s + 1) & (new_cap - 1);
        table_occ[new_base + s] = 1;
        table_keys[new_base + s] = table_keys[old_base + i];
        table_vals[new_base + s] = table_vals[old_base + i];
        table_occ[old_base + i] = 0;
      end
    end
    cur_bank ^= 1;
    cur_log2++;
  endfunction

  function automatic insert_result_t apply_op(table_op_t t);
    insert_result_t r;
    probe_t p;
    int s;
    s = 0;
    if (t.op == OP_CLEAR) begin
      for (int i = 0; i < DEPTH; i++) table_occ[i] = 0;
      cur_bank = 0;
      cur_log2 = START_LOG2;
      cur_count = 0;
      r.status = ST_CLEARED;
    end else begin
      p = find_slot(t.k, s);
      if (p == PROBE_MATCH) begin
        table_vals[cur_bank * BANK + s] = t.v;
        r.status = ST_REPLACED;
      end else if (p == PROBE_NONE) begin
        s = 0;
        r.status = ST_FULL;
      end else begin
        if (16 * longint'(cur_count + 1) > longint'(threshold) * (longint'(1) << cur_log2)
            && cur_log2 < MAX_LOG2) begin
          rehash_double();
          p = find_slot(t.k, s);
        end
        table_occ[cur_bank * BANK + s] = 1;
        table_keys[cur_bank * BANK + s] = t.k;
        table_vals[cur_bank * BANK + s] = t.v;
        cur_count++;
        r.status = ST_NEW;
      end
    end
    r.slot = 10'(s);
    r.count = 11'(cur_count);
    r.lg = 4'(cur_log2);
    return r;
  endfunction

  always @(posedge clk) begin
    table_op_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        t.op = opcode;
        t.k = key;
        t.v = value;
        expected_results.push_back(apply_op(t));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          t = pending_ops.pop_front();
          opcode <= t.op;
          key <= t.k;
          value <= t.v;
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    insert_result_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation: slot %0d status %0d", slot, status);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (slot !== e.slot) begin
            $error("slot: expected %0d, got %0d", e.slot, slot);
            errors++;
          end
          if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            errors++;
          end
          if (entry_count !== e.count) begin
            $error("entry_count: expected %0d, got %0d", e.count, entry_count);
            errors++;
          end
          if (capacity_log2 !== e.lg) begin
            $error("capacity_log2: expected %0d, got %0d", e.lg, capacity_log2);
            errors++;
          end
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 9) == 0) out_hold = $urandom_range(1, 16);
      end
    end
  end

  task automatic add_op(logic op, logic [31:0] k, logic [63:0] v);
    table_op_t t;
    t.op = op;
    t.k = k;
    t.v = v;
    pending_ops.push_back(t);
    if (op == OP_INSERT) begin
      key_pool.push_back(k);
      if (key_pool.size() > 48) void'(key_pool.pop_front());
    end
  endtask

  task automatic drain();
    wait (pending_ops.size() == 0);
    do @(posedge clk); while (in_valid || expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_GROW_THRESHOLD;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    threshold = int'(v & 32'h1F);
  endtask

  task automatic random_phase(int n);
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 59) == 0) begin
        add_op(OP_CLEAR, $urandom, {$urandom, $urandom});
      end else begin
        if (key_pool.size() > 0 && $urandom_range(0, 9) < 4)
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
          k = $urandom;
        add_op(OP_INSERT, k, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    int limits[6];
    limits = '{16, 1, 8, 31, 5, 12};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    add_op(OP_INSERT, 32'h0000_0000, 64'h0);
    add_op(OP_INSERT, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_op(OP_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0001);
    add_op(OP_INSERT, 32'hFFFF_FFFF, 64'h5555_AAAA_5555_AAAA);
    add_op(OP_INSERT, 32'h7FFF_FFFF, 64'h0);
    add_op(OP_INSERT, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    add_op(OP_CLEAR, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();

    write_threshold(31);
    for (int i = 0; i < 17; i++) add_op(OP_INSERT, 32'(i * 16 + 3), 64'(i));
    add_op(OP_INSERT, 32'd3, 64'hDEAD_BEEF);
    drain();

    write_threshold(0);
    add_op(OP_CLEAR, 32'h0, 64'h0);
    for (int i = 0; i < 8; i++) add_op(OP_INSERT, $urandom, {$urandom, $urandom});
    drain();

    foreach (limits[p]) begin
      if (p == 5) calm = 1;
      write_threshold(limits[p]);
      random_phase(125);
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lph_pkg.sv
rtl/lph_ram.sv
rtl/lph_datapath.sv
rtl/lph_ctrl.sv
rtl/linear_probe_hash_insert.sv
bench/linear_probe_hash_insert_test.sv
